// ===== rtl/wsdf_pkg.sv =====
// Shared types, codes and helpers for the WebSocket frame deframer.
package wsdf_pkg;

    localparam int LEN_W   = 63;
    localparam int TDATA_W = 80;

    // Parse phases of the receive side.
    typedef enum logic [2:0] {
        PH_HEAD0   = 3'd0,
        PH_HEAD1   = 3'd1,
        PH_LEN16   = 3'd2,
        PH_LEN64   = 3'd3,
        PH_KEY     = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_ERROR   = 3'd6
    } phase_t;

    // Result kinds carried on tuser.
    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    // Length codes in the second header byte.
    localparam logic [6:0] LEN_CODE16 = 7'd126;
    localparam logic [6:0] LEN_CODE64 = 7'd127;

    // Defined opcodes.
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // One result as it leaves the parser.
    typedef struct packed {
        kind_t              kind;
        logic               fin;
        logic [3:0]         opcode;
        logic               masked;
        logic [LEN_W-1:0]   length;
        logic [7:0]         pbyte;
        logic               last;
    } result_t;

    function automatic logic opcode_ok(input logic [3:0] op);
        return op inside {OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG};
    endfunction

endpackage

// ===== rtl/wsdf_parser.sv =====
// Frame parse state and the combinational step that takes one byte and, for some bytes, yields a result.
module wsdf_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  logic [7:0]         data_byte,
    output logic               res_valid,
    output wsdf_pkg::result_t  res
);
    import wsdf_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [2:0]       count_reg, count_next;
    logic             fin_reg, fin_next;
    logic [3:0]       opcode_reg, opcode_next;
    logic             masked_reg, masked_next;
    logic [2:0]       rsv_reg, rsv_next;
    logic [LEN_W-1:0] length_reg, length_next;
    logic [LEN_W-1:0] remain_reg, remain_next;
    logic [31:0]      key_reg, key_next;

    logic [6:0]       code;
    logic             hdr_ok;
    logic [LEN_W-1:0] len_shift;
    logic             len16_end;
    logic             len64_end;
    logic [7:0]       key_byte;
    logic             valid_c;

    assign code      = data_byte[6:0];
    assign hdr_ok    = (rsv_reg == 3'd0) && opcode_ok(opcode_reg);
    assign len_shift = {length_reg[LEN_W-9:0], data_byte};
    assign len16_end = (count_reg == 3'd1);
    assign len64_end = (count_reg == 3'd7);

    always_comb begin
        case (count_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_HEAD0: phase_next = PH_HEAD1;
            PH_HEAD1: begin
                if (!hdr_ok) begin
                    phase_next = PH_ERROR;
                end else if (code == LEN_CODE16) begin
                    phase_next = PH_LEN16;
                end else if (code == LEN_CODE64) begin
                    phase_next = PH_LEN64;
                end else if (data_byte[7]) begin
                    phase_next = PH_KEY;
                end else if (code == 7'd0) begin
                    phase_next = PH_HEAD0;
                end else begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_LEN16, PH_LEN64: begin
                if ((phase_reg == PH_LEN16 && len16_end) ||
                    (phase_reg == PH_LEN64 && len64_end)) begin
                    if (masked_reg) begin
                        phase_next = PH_KEY;
                    end else if (len_shift == '0) begin
                        phase_next = PH_HEAD0;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_KEY: begin
                if (count_reg == 3'd3) begin
                    phase_next = (length_reg == '0) ? PH_HEAD0 : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (remain_reg == LEN_W'(1)) begin
                    phase_next = PH_HEAD0;
                end
            end
            PH_ERROR: phase_next = PH_ERROR;
            default:  phase_next = PH_ERROR;
        endcase
    end

    // Header fields, length, counters and key.
    always_comb begin
        count_next  = count_reg;
        fin_next    = fin_reg;
        opcode_next = opcode_reg;
        masked_next = masked_reg;
        rsv_next    = rsv_reg;
        length_next = length_reg;
        remain_next = remain_reg;
        key_next    = key_reg;
        case (phase_reg)
            PH_HEAD0: begin
                fin_next    = data_byte[7];
                rsv_next    = data_byte[6:4];
                opcode_next = data_byte[3:0];
                masked_next = 1'b0;
            end
            PH_HEAD1: begin
                masked_next = data_byte[7];
                if (hdr_ok) begin
                    count_next = 3'd0;
                    if (code == LEN_CODE16 || code == LEN_CODE64) begin
                        length_next = '0;
                    end else begin
                        length_next = LEN_W'(code);
                    end
                    remain_next = length_next;
                end
            end
            PH_LEN16, PH_LEN64: begin
                length_next = len_shift;
                remain_next = len_shift;
                count_next  = count_reg + 3'd1;
                if ((phase_reg == PH_LEN16 && len16_end) ||
                    (phase_reg == PH_LEN64 && len64_end)) begin
                    count_next = 3'd0;
                end
            end
            PH_KEY: begin
                key_next   = {key_reg[23:0], data_byte};
                count_next = (count_reg == 3'd3) ? 3'd0 : count_reg + 3'd1;
            end
            PH_PAYLOAD: begin
                count_next  = {1'b0, count_reg[1:0] + 2'd1};
                remain_next = remain_reg - LEN_W'(1);
            end
            default: ;
        endcase
    end

    // Result for the current byte.
    always_comb begin
        valid_c    = 1'b0;
        res.kind   = KIND_HEADER;
        res.fin    = fin_reg;
        res.opcode = opcode_reg;
        res.masked = masked_reg;
        res.length = '0;
        res.pbyte  = 8'd0;
        res.last   = 1'b0;
        case (phase_reg)
            PH_HEAD1: begin
                res.masked = data_byte[7];
                if (!hdr_ok) begin
                    valid_c  = 1'b1;
                    res.kind = KIND_ERROR;
                    res.last = 1'b1;
                end else if (code != LEN_CODE16 && code != LEN_CODE64 && !data_byte[7]) begin
                    valid_c    = 1'b1;
                    res.length = LEN_W'(code);
                    res.last   = (code == 7'd0);
                end
            end
            PH_LEN16, PH_LEN64: begin
                if (((phase_reg == PH_LEN16 && len16_end) ||
                     (phase_reg == PH_LEN64 && len64_end)) && !masked_reg) begin
                    valid_c    = 1'b1;
                    res.length = len_shift;
                    res.last   = (len_shift == '0);
                end
            end
            PH_KEY: begin
                if (count_reg == 3'd3) begin
                    valid_c    = 1'b1;
                    res.length = length_reg;
                    res.last   = (length_reg == '0);
                end
            end
            PH_PAYLOAD: begin
                valid_c    = 1'b1;
                res.kind   = KIND_PAYLOAD;
                res.length = length_reg;
                res.pbyte  = masked_reg ? (data_byte ^ key_byte) : data_byte;
                res.last   = (remain_reg == LEN_W'(1));
            end
            default: ;
        endcase
    end

    assign res_valid = step && valid_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEAD0;
            count_reg  <= 3'd0;
            fin_reg    <= 1'b0;
            opcode_reg <= 4'd0;
            masked_reg <= 1'b0;
            rsv_reg    <= 3'd0;
            length_reg <= '0;
            remain_reg <= '0;
            key_reg    <= 32'd0;
        end else if (step) begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            fin_reg    <= fin_next;
            opcode_reg <= opcode_next;
            masked_reg <= masked_next;
            rsv_reg    <= rsv_next;
            length_reg <= length_next;
            remain_reg <= remain_next;
            key_reg    <= key_next;
        end
    end

endmodule

// ===== rtl/websocket_frame_deframer_core.sv =====
// Top level of the WebSocket frame deframer: input register, parser and result register.
//
//  Channel | Direction | Ports                          | Carries
//  --------+-----------+--------------------------------+-------------------------------------
//  s_      | in        | s_tvalid s_tready s_tdata      | one received byte per request
//  m_      | out       | m_tvalid m_tready m_tdata      | header, payload byte or error result
//          |           | m_tuser m_tlast                |
//
// One byte is taken per cycle unless a waiting result with m_tready low holds the flow. The
// parser sits between the input register and the result register and handles each byte
// combinationally. A result is presented after its byte passes the input and result registers.
// Header, length and key bytes produce no result, except the byte that completes the header
// or shows a header error. Reset (aresetn low at a clock edge) empties both registers and
// puts the parser back to the first header byte; there is no clearing pass. While a result
// waits with m_tready low, the result register holds and the input register still takes
// one more byte if it is empty before s_tready drops.
module websocket_frame_deframer_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] data_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] fin, [4:1] opcode, [5] masked, [68:6] payload_length, [76:69] payload_byte,
    // [79:77] zero
    output logic [wsdf_pkg::TDATA_W-1:0]  m_tdata,
    output logic [1:0]                    m_tuser,   // [1:0] kind
    output logic                          m_tlast    // last result of the frame
);
    import wsdf_pkg::*;

    // The input register holds one byte until the parser can hand its result on.
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;

    // The result register faces the master side.
    logic        out_valid_reg, out_valid_next;
    result_t     out_res_reg;

    logic        advance;
    logic        res_valid;
    result_t     res;

    // A byte moves through the parser whenever the result register is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = res_valid;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    wsdf_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .data_byte (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (advance && res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_res_reg.pbyte, out_res_reg.length, out_res_reg.masked,
                       out_res_reg.opcode, out_res_reg.fin};
    assign m_tuser  = out_res_reg.kind;
    assign m_tlast  = out_res_reg.last;

    // An error result always closes the frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_ERROR) |-> m_tlast)
        else $error("error result without last");

    // A header result is the last one exactly when the frame is empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_HEADER) |-> (m_tlast == (m_tdata[68:6] == '0)))
        else $error("header last flag disagrees with length");

    // Only payload results carry a data byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != KIND_PAYLOAD) |-> (m_tdata[76:69] == 8'd0))
        else $error("nonzero payload byte on header or error result");

endmodule

// ===== tb/wsdf_frame_checker.sv =====
// Checker for the WebSocket frame deframer: predicts each result from the accepted bytes.
module wsdf_frame_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [7:0]                    s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [wsdf_pkg::TDATA_W-1:0]  m_tdata,
    input  logic [1:0]                    m_tuser,
    input  logic                          m_tlast,
    output int                            mismatches,
    output int                            waiting,
    output int                            n_headers,
    output int                            n_payload,
    output int                            n_errors
);
    import wsdf_pkg::*;

    // Parser state as the block should hold it.
    phase_t           rx_phase;
    logic [2:0]       step_cnt;
    logic             cur_fin;
    logic [3:0]       cur_op;
    logic             cur_masked;
    logic [2:0]       cur_rsv;
    logic [LEN_W-1:0] cur_len;
    logic [LEN_W-1:0] left;
    logic [31:0]      key;

    result_t results_due[$];

    initial begin
        mismatches = 0;
        waiting    = 0;
        n_headers  = 0;
        n_payload  = 0;
        n_errors   = 0;
    end

    function automatic logic legal_opcode(input logic [3:0] op);
        case (op)
            OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic result_t form_result(input kind_t k, input logic [LEN_W-1:0] len,
                                            input logic [7:0] pb, input logic fl);
        result_t r;
        r.kind   = k;
        r.fin    = cur_fin;
        r.opcode = cur_op;
        r.masked = cur_masked;
        r.length = len;
        r.pbyte  = pb;
        r.last   = fl;
        return r;
    endfunction

    task automatic header_done();
        if (cur_len == '0) begin
            results_due.push_back(form_result(KIND_HEADER, '0, 8'h00, 1'b1));
            rx_phase = PH_HEAD0;
        end else begin
            results_due.push_back(form_result(KIND_HEADER, cur_len, 8'h00, 1'b0));
            left     = cur_len;
            step_cnt = '0;
            rx_phase = PH_PAYLOAD;
        end
    endtask

    // A masked frame still has its four key bytes to come.
    task automatic length_known();
        if (cur_masked) begin
            step_cnt = '0;
            key      = '0;
            rx_phase = PH_KEY;
        end else begin
            header_done();
        end
    endtask

    task automatic parse_byte(input logic [7:0] b);
        logic [7:0] v;
        case (rx_phase)
            PH_HEAD0: begin
                cur_fin    = b[7];
                cur_rsv    = b[6:4];
                cur_op     = b[3:0];
                cur_masked = 1'b0;
                rx_phase   = PH_HEAD1;
            end
            PH_HEAD1: begin
                cur_masked = b[7];
                if (cur_rsv != 3'd0 || !legal_opcode(cur_op)) begin
                    results_due.push_back(form_result(KIND_ERROR, '0, 8'h00, 1'b1));
                    rx_phase = PH_ERROR;
                end else begin
                    cur_len  = '0;
                    step_cnt = '0;
                    if (b[6:0] == LEN_CODE16) begin
                        rx_phase = PH_LEN16;
                    end else if (b[6:0] == LEN_CODE64) begin
                        rx_phase = PH_LEN64;
                    end else begin
                        cur_len = LEN_W'(b[6:0]);
                        length_known();
                    end
                end
            end
            PH_LEN16, PH_LEN64: begin
                // Shifting through 63 bits drops bit 63 of the long form.
                cur_len  = {cur_len[LEN_W-9:0], b};
                step_cnt = step_cnt + 3'd1;
                if ((rx_phase == PH_LEN16 && step_cnt == 3'd2) ||
                    (rx_phase == PH_LEN64 && step_cnt == 3'd0)) begin
                    step_cnt = '0;
                    length_known();
                end
            end
            PH_KEY: begin
                key      = {key[23:0], b};
                step_cnt = step_cnt + 3'd1;
                if (step_cnt == 3'd4)
                    header_done();
            end
            PH_PAYLOAD: begin
                v = b;
                if (cur_masked)
                    v = b ^ key[8 * (3 - step_cnt[1:0]) +: 8];
                step_cnt = {1'b0, step_cnt[1:0] + 2'd1};
                left     = left - 1'b1;
                results_due.push_back(form_result(KIND_PAYLOAD, cur_len, v, left == '0));
                if (left == '0)
                    rx_phase = PH_HEAD0;
            end
            default: rx_phase = PH_ERROR;
        endcase
    endtask

    task automatic check_field(input string field, input logic [LEN_W-1:0] want,
                               input logic [LEN_W-1:0] seen);
        if (want !== seen) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, seen);
        end
    endtask

    task automatic check_result();
        result_t want;
        if (results_due.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, got kind %0d tdata %0h",
                     $time, m_tuser, m_tdata);
        end else begin
            want = results_due.pop_front();
            check_field("kind", LEN_W'(want.kind), LEN_W'(m_tuser));
            check_field("fin", LEN_W'(want.fin), LEN_W'(m_tdata[0]));
            check_field("opcode", LEN_W'(want.opcode), LEN_W'(m_tdata[4:1]));
            check_field("masked", LEN_W'(want.masked), LEN_W'(m_tdata[5]));
            check_field("payload_length", want.length, m_tdata[68:6]);
            check_field("payload_byte", LEN_W'(want.pbyte), LEN_W'(m_tdata[76:69]));
            check_field("last", LEN_W'(want.last), LEN_W'(m_tlast));
            check_field("tdata padding", '0, LEN_W'(m_tdata[79:77]));
            case (want.kind)
                KIND_HEADER:  n_headers++;
                KIND_PAYLOAD: n_payload++;
                default:      n_errors++;
            endcase
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            rx_phase   = PH_HEAD0;
            step_cnt   = '0;
            cur_fin    = 1'b0;
            cur_op     = '0;
            cur_masked = 1'b0;
            cur_rsv    = '0;
            cur_len    = '0;
            left       = '0;
            key        = '0;
            results_due.delete();
        end else begin
            if (s_tvalid && s_tready)
                parse_byte(s_tdata);
            if (m_tvalid && m_tready)
                check_result();
        end
        waiting = results_due.size();
    end

endmodule

// ===== tb/websocket_frame_deframer_core_tb.sv =====
// Testbench top for the WebSocket frame deframer: byte stimulus, flow control and verdict.
module websocket_frame_deframer_core_tb;
    import wsdf_pkg::*;

    // Ways to encode the payload length in the header.
    localparam int FORM_SHORT = 0;
    localparam int FORM_LEN16 = 1;
    localparam int FORM_LEN64 = 2;

    // Far above the slowest correct run.
    localparam int CYCLE_LIMIT = 400000;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = 8'h00;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;

    int mismatches;
    int waiting;
    int n_headers;
    int n_payload;
    int n_errors;

    int sent               = 0;
    int cycles             = 0;
    int sender_gap_pct     = 0;
    int receiver_stall_pct = 0;

    logic [3:0] frame_ops [6] = '{OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG};

    always #2 aclk = ~aclk;

    websocket_frame_deframer_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // The checker sees both channels exactly as the block does and keeps the failure count.
    wsdf_frame_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .waiting    (waiting),
        .n_headers  (n_headers),
        .n_payload  (n_payload),
        .n_errors   (n_errors)
    );

    // The result side stalls at random; the rate follows the current flow-control phase.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("websocket_frame_deframer_core test failed");
            $finish;
        end
    end

    // Offers one byte as a request and returns at the falling edge after it was taken.
    // Random gaps come first, so valid drops only between requests, never mid-request.
    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(99) < sender_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
        sent++;
    endtask

    // Sends one well-formed frame: header, optional extended length, optional key, payload.
    // The payload bytes and the key are random.
    task automatic send_frame(input logic fin, input logic [3:0] op, input logic msk,
                              input int unsigned len, input int form, input logic top_bit);
        logic [63:0] len64;
        len64 = {top_bit, 63'(len)};
        push_byte({fin, 3'b000, op});
        case (form)
            FORM_LEN16: begin
                push_byte({msk, LEN_CODE16});
                push_byte(len64[15:8]);
                push_byte(len64[7:0]);
            end
            FORM_LEN64: begin
                push_byte({msk, LEN_CODE64});
                for (int i = 7; i >= 0; i--)
                    push_byte(len64[8 * i +: 8]);
            end
            default: push_byte({msk, 7'(len)});
        endcase
        if (msk) begin
            repeat (4)
                push_byte(8'($urandom));
        end
        repeat (len)
            push_byte(8'($urandom));
    endtask

    // Random frame: mostly short payloads, with some longer ones and all three length forms,
    // including non-minimal encodings and the long form with its top bit set.
    task automatic random_frame();
        int          r;
        int          form;
        int unsigned len;
        r = $urandom_range(99);
        if (r < 65) begin
            form = FORM_SHORT;
            len  = $urandom_range(8);
        end else if (r < 75) begin
            form = FORM_SHORT;
            len  = $urandom_range(125, 9);
        end else if (r < 87) begin
            form = FORM_LEN16;
            len  = ($urandom_range(3) == 0) ? $urandom_range(3) : $urandom_range(200);
        end else begin
            form = FORM_LEN64;
            len  = $urandom_range(40);
        end
        send_frame(1'($urandom), frame_ops[$urandom_range(5)], ($urandom_range(9) < 7),
                   len, form, 1'($urandom));
    endtask

    initial begin
        logic [7:0] bad_head;
        logic [3:0] bad_op;

        // Reset is held at the start and never again.
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // First flow-control phase: the sender idles a little, the receiver a lot.
        sender_gap_pct     = 18;
        receiver_stall_pct = 71;

        // Directed frames. A zero-length unmasked continuation ends at its header.
        send_frame(1'b0, OP_CONT, 1'b0, 0, FORM_SHORT, 1'b0);
        // A masked text frame; the payload walks through the key bytes.
        send_frame(1'b1, OP_TEXT, 1'b1, 3, FORM_SHORT, 1'b0);
        // A non-minimal 16-bit length that is zero.
        send_frame(1'b1, OP_CLOSE, 1'b0, 0, FORM_LEN16, 1'b0);
        // A 64-bit length with bit 63 set: the bit is dropped, so the length is zero.
        send_frame(1'b1, OP_PING, 1'b0, 0, FORM_LEN64, 1'b1);
        // A masked zero-length frame still reads its key before the header result.
        send_frame(1'b0, OP_PONG, 1'b1, 0, FORM_SHORT, 1'b0);

        // Random frames, with the idling swapped after a third and dropped after two thirds.
        while (sent < 900) begin
            if (sent < 300) begin
                sender_gap_pct     = 18;
                receiver_stall_pct = 71;
            end else if (sent < 600) begin
                sender_gap_pct     = 71;
                receiver_stall_pct = 18;
            end else begin
                sender_gap_pct     = 0;
                receiver_stall_pct = 0;
            end
            random_frame();
        end

        // The protocol error is sticky until reset, so it closes the run: a header with either
        // reserved bits set or an undefined opcode, then bytes the block must ignore.
        if ($urandom_range(1)) begin
            bad_head = {1'($urandom), 3'($urandom_range(7, 1)), 4'($urandom)};
        end else begin
            bad_op = 4'($urandom);
            while (bad_op inside {OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG})
                bad_op = 4'($urandom);
            bad_head = {1'($urandom), 3'b000, bad_op};
        end
        push_byte(bad_head);
        push_byte(8'($urandom));
        repeat (12)
            push_byte(8'($urandom));
        s_tvalid <= 1'b0;

        // Drain: every predicted result must arrive, then a quiet spell catches extra ones.
        while (waiting != 0)
            @(negedge aclk);
        repeat (20) @(negedge aclk);

        $display("Sent %0d bytes over three flow-control phases; checked %0d headers,",
                 sent, n_headers);
        $display("%0d payload bytes and %0d protocol error results.", n_payload, n_errors);
        if (mismatches == 0)
            $display("websocket_frame_deframer_core test passed");
        else
            $display("websocket_frame_deframer_core test failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/wsdf_pkg.sv
rtl/wsdf_parser.sv
rtl/websocket_frame_deframer_core.sv
tb/wsdf_frame_checker.sv
tb/websocket_frame_deframer_core_tb.sv
